[hw/rtl/vclp_pkg.sv]
package vclp_pkg;

   // Q2.14 command values
   localparam int unsigned Q_FRAC_BITS = 14;

   // which stored value a token updates; also the bit index in the seen mask
   localparam logic [1:0] SEL_LX  = 2'd0;
   localparam logic [1:0] SEL_LY  = 2'd1;
   localparam logic [1:0] SEL_YAW = 2'd2;

   localparam int unsigned POW10 [10] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
      32'd10000000, 32'd100000000, 32'd1000000000
   };

   typedef struct packed {
      logic       is_line;
      logic [1:0] key_sel;
      logic       negative;
      logic [1:0] int_part;
   } vclp_token_type;

endpackage

[hw/rtl/velocity_command_line_parser.sv]
// Velocity command line parser: takes command text one byte per transaction,
// lines of the form "lx:<v>;ly:<v>;yaw:<v>;" ended by newline, and on a newline
// after all three keys were seen in that line produces one transaction of four
// mecanum wheel setpoints (rad/s in 1/256 units, rounded and clamped to
// +/-393216). Values are parsed to Q2.14 with FRACTION_DIGITS fraction digits.
// A byte is taken every cycle while full is low. The front end classifies each
// byte in that cycle; each keyed value token is queued for the back end, which
// converts it in the steps queue pop, reciprocal multiply, quotient estimate,
// one-step correction and store, and a complete line passes through pop,
// multiply and mix. QUEUE_DEPTH records decouple the two, so full rises only
// when tokens arrive faster than the back end converts them for longer than
// the queue covers, or when it fills while a mixed line waits for an unpopped
// result. A finished result waits in its own register while parsing continues.
// No clearing pass follows reset. Gains sit at byte addresses 0 and 4.
module velocity_command_line_parser
   import vclp_pkg::*;
#(
   parameter int FRACTION_DIGITS = 5,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   // command bytes
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_rx_byte,
   // wheel setpoints
   output logic               empty,
   input  logic               pop,
   output logic signed [19:0] rsp_front_left_speed,
   output logic signed [19:0] rsp_back_left_speed,
   output logic signed [19:0] rsp_front_right_speed,
   output logic signed [19:0] rsp_back_right_speed,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // scaled fraction field, wide enough for 10^FRACTION_DIGITS - 1
   localparam int FW = $clog2(POW10[FRACTION_DIGITS]);
   localparam int TOKEN_BITS = $bits(vclp_token_type);

   localparam logic REG_FORWARD_GAIN = 1'b0;
   localparam logic REG_TURN_GAIN    = 1'b1;

   logic [15:0] forward_gain_ff, turn_gain_ff;
   logic        csr_write;

   logic           accept;
   logic           rec_valid;
   vclp_token_type rec;
   logic [FW-1:0]  rec_frac;

   logic           q_valid, q_pop;
   logic [TOKEN_BITS+FW-1:0] q_data;
   vclp_token_type q_tok;
   logic [FW-1:0]  q_frac;

   logic           out_valid;

   // register port: zero wait states, write on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[2])
         REG_FORWARD_GAIN: prdata = {16'd0, forward_gain_ff};
         REG_TURN_GAIN:    prdata = {16'd0, turn_gain_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_gain_ff <= 16'd2560;
         turn_gain_ff    <= 16'd2560;
      end else if (csr_write) begin
         case (paddr[2])
            REG_FORWARD_GAIN: forward_gain_ff <= pwdata[15:0];
            REG_TURN_GAIN:    turn_gain_ff    <= pwdata[15:0];
            default:          turn_gain_ff    <= turn_gain_ff;
         endcase
      end
   end

   // hold off bytes whenever the record queue has no room
   assign accept = push && !full;

   vclp_front #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .FW              (FW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .rec_valid (rec_valid),
      .rec       (rec),
      .rec_frac  (rec_frac)
   );

   vclp_queue #(
      .WIDTH (TOKEN_BITS + FW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rec_valid),
      .wr_data  ({rec, rec_frac}),
      .full     (full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   assign {q_tok, q_frac} = q_data;

   vclp_back #(
      .FRACTION_DIGITS (FRACTION_DIGITS),
      .FW              (FW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .tok_valid         (q_valid),
      .tok               (q_tok),
      .tok_frac          (q_frac),
      .tok_pop           (q_pop),
      .forward_gain      (forward_gain_ff),
      .turn_gain         (turn_gain_ff),
      .pop               (pop),
      .out_valid         (out_valid),
      .front_left_speed  (rsp_front_left_speed),
      .back_left_speed   (rsp_back_left_speed),
      .front_right_speed (rsp_front_right_speed),
      .back_right_speed  (rsp_back_right_speed)
   );

   assign empty = !out_valid;

endmodule

[hw/rtl/vclp_queue.sv]
module vclp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hw/rtl/vclp_front.sv]
module vclp_front
   import vclp_pkg::*;
#(
   parameter int FRACTION_DIGITS = 5,
   parameter int FW = 17
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   output logic           rec_valid,
   output vclp_token_type rec,
   output logic [FW-1:0]  rec_frac
);

   localparam int CW = $clog2(FRACTION_DIGITS + 1);

   localparam logic [2:0] PH_LINE_START = 3'd0;
   localparam logic [2:0] PH_KEY        = 3'd1;
   localparam logic [2:0] PH_VAL_WS     = 3'd2;
   localparam logic [2:0] PH_VAL_INT    = 3'd3;
   localparam logic [2:0] PH_VAL_FRAC   = 3'd4;
   localparam logic [2:0] PH_VAL_DONE   = 3'd5;

   localparam logic [2:0] KM_EMPTY = 3'd0;
   localparam logic [2:0] KM_L     = 3'd1;
   localparam logic [2:0] KM_LX    = 3'd2;
   localparam logic [2:0] KM_LY    = 3'd3;
   localparam logic [2:0] KM_Y     = 3'd4;
   localparam logic [2:0] KM_YA    = 3'd5;
   localparam logic [2:0] KM_YAW   = 3'd6;
   localparam logic [2:0] KM_BAD   = 3'd7;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_Y     = 8'h79;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_W     = 8'h77;

   localparam logic [2:0] SEEN_ALL = 3'b111;

   function automatic logic [2:0] next_key(input logic [2:0] km, input logic [7:0] b);
      logic [2:0] nk;
      nk = KM_BAD;
      case (km)
         KM_EMPTY: begin
            if (b == CH_L) nk = KM_L;
            else if (b == CH_Y) nk = KM_Y;
         end
         KM_L: begin
            if (b == CH_X) nk = KM_LX;
            else if (b == CH_Y) nk = KM_LY;
         end
         KM_Y: begin
            if (b == CH_A) nk = KM_YA;
         end
         KM_YA: begin
            if (b == CH_W) nk = KM_YAW;
         end
         default: nk = KM_BAD;
      endcase
      return nk;
   endfunction

   logic [2:0]    phase_ff, phase_in, phase_eff;
   logic [2:0]    key_ff, key_in;
   logic          neg_ff, neg_in;
   logic [1:0]    int_ff, int_in;
   logic [FW-1:0] frac_ff, frac_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    seen_ff, seen_in;

   logic          blank, digit, key_hit;
   logic [3:0]    digit_val;
   logic [3:0]    weight_idx;
   logic [1:0]    hit_sel;
   logic [1:0]    int_digit;
   logic [FW-1:0] frac_add;

   assign blank = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0D) ||
                  (rx_byte == 8'h0B) || (rx_byte == 8'h0C);
   assign digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
   assign digit_val = rx_byte[3:0];
   assign phase_eff = (phase_ff == PH_LINE_START) ? PH_KEY : phase_ff;

   // saturating integer part: any value above 3 pins at 3
   assign int_digit = ((int_ff != 2'd0) || (digit_val > 4'd3)) ? 2'd3 : digit_val[1:0];

   // fraction kept already scaled to FRACTION_DIGITS places
   assign weight_idx = 4'(FRACTION_DIGITS - 1 - int'(count_ff));
   assign frac_add   = FW'(32'(digit_val) * POW10[weight_idx]);

   always_comb begin
      key_hit = 1'b1;
      hit_sel = SEL_LX;
      case (key_ff)
         KM_LX:   hit_sel = SEL_LX;
         KM_LY:   hit_sel = SEL_LY;
         KM_YAW:  hit_sel = SEL_YAW;
         default: key_hit = 1'b0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      key_in    = key_ff;
      neg_in    = neg_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      rec_valid = 1'b0;
      rec       = '0;
      rec_frac  = frac_ff;
      rec.key_sel  = hit_sel;
      rec.negative = neg_ff;
      rec.int_part = int_ff;
      if (accept) begin
         if (rx_byte == CH_NL) begin
            if (seen_ff == SEEN_ALL) begin
               rec_valid   = 1'b1;
               rec.is_line = 1'b1;
            end
            phase_in = PH_LINE_START;
            key_in   = KM_EMPTY;
            neg_in   = 1'b0;
            int_in   = '0;
            frac_in  = '0;
            count_in = '0;
            seen_in  = '0;
         end else if (!(phase_ff == PH_LINE_START && blank)) begin
            phase_in = phase_eff;
            if (rx_byte == CH_SEMI) begin
               // close the token; only a keyed value goes on to the back end
               if (phase_eff != PH_KEY && key_hit) begin
                  rec_valid = 1'b1;
                  seen_in   = seen_ff | (3'b001 << hit_sel);
               end
               phase_in = PH_KEY;
               key_in   = KM_EMPTY;
               neg_in   = 1'b0;
               int_in   = '0;
               frac_in  = '0;
               count_in = '0;
            end else begin
               case (phase_eff)
                  PH_KEY: begin
                     if (rx_byte == CH_COLON) phase_in = PH_VAL_WS;
                     else key_in = next_key(key_ff, rx_byte);
                  end
                  PH_VAL_WS: begin
                     if (blank) begin
                        phase_in = PH_VAL_WS;
                     end else if (rx_byte == CH_PLUS) begin
                        phase_in = PH_VAL_INT;
                     end else if (rx_byte == CH_MINUS) begin
                        neg_in   = 1'b1;
                        phase_in = PH_VAL_INT;
                     end else if (digit) begin
                        int_in   = int_digit;
                        phase_in = PH_VAL_INT;
                     end else if (rx_byte == CH_DOT) begin
                        phase_in = PH_VAL_FRAC;
                     end else begin
                        phase_in = PH_VAL_DONE;
                     end
                  end
                  PH_VAL_INT: begin
                     if (digit) int_in = int_digit;
                     else if (rx_byte == CH_DOT) phase_in = PH_VAL_FRAC;
                     else phase_in = PH_VAL_DONE;
                  end
                  PH_VAL_FRAC: begin
                     if (digit) begin
                        if (count_ff < CW'(FRACTION_DIGITS)) begin
                           frac_in  = frac_ff + frac_add;
                           count_in = count_ff + 1'b1;
                        end
                     end else begin
                        phase_in = PH_VAL_DONE;
                     end
                  end
                  default: phase_in = phase_eff;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE_START;
         key_ff   <= KM_EMPTY;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         count_ff <= '0;
         seen_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         key_ff   <= key_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

[hw/rtl/vclp_back.sv]
module vclp_back
   import vclp_pkg::*;
#(
   parameter int FRACTION_DIGITS = 5,
   parameter int FW = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  vclp_token_type      tok,
   input  logic [FW-1:0]       tok_frac,
   output logic                tok_pop,
   input  logic [15:0]         forward_gain,
   input  logic [15:0]         turn_gain,
   input  logic                pop,
   output logic                out_valid,
   output logic signed [19:0]  front_left_speed,
   output logic signed [19:0]  back_left_speed,
   output logic signed [19:0]  front_right_speed,
   output logic signed [19:0]  back_right_speed
);

   localparam int unsigned SCALE = POW10[FRACTION_DIGITS];
   // rounded numerator frac * 2^14 + SCALE/2 stays below 2^NW
   localparam int NW = FW + Q_FRAC_BITS;
   // floor(2^NW / SCALE); SCALE is above 2^(FW-1), so this fits 15 bits
   localparam logic [14:0]    RECIP      = 15'((64'd1 << NW) / 64'(SCALE));
   localparam logic [NW-1:0]  HALF_SCALE = NW'(SCALE / 2);
   localparam logic [NW:0]    SCALE_N    = (NW + 1)'(SCALE);
   localparam logic [NW+14:0] HALF_RECIP = (NW + 15)'(64'(SCALE / 2) * 64'(RECIP));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RCP  = 3'd1;
   localparam logic [2:0] ST_EST  = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_SUM  = 3'd6;

   localparam logic [20:0] SPEED_LIMIT = 21'd393216;

   // round a 2^-22 sum to 1/256, ties away from zero, and clamp
   function automatic logic signed [19:0] mix_speed(input logic signed [34:0] s);
      logic [34:0] mag;
      logic [34:0] rnd;
      logic [20:0] lim;
      mag = s[34] ? 35'(-s) : 35'(s);
      rnd = (mag + 35'd8192) >> Q_FRAC_BITS;
      lim = (rnd > 35'(SPEED_LIMIT)) ? SPEED_LIMIT : rnd[20:0];
      return s[34] ? 20'(-lim) : 20'(lim);
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [FW-1:0]        frac_ff, frac_in;
   logic [FW+14:0]       prod_ff;
   logic [14:0]          quot_ff, quot_in;
   vclp_token_type       cur_ff, cur_in;
   logic signed [15:0]   strafe_ff, forward_ff, turn_ff;
   logic signed [32:0]   fw_prod_ff, st_prod_ff, tn_prod_ff;
   logic                 out_valid_ff, out_valid_in;
   logic signed [19:0]   fl_ff, bl_ff, fr_ff, br_ff;

   logic [NW+14:0]       est_sum;
   logic [NW-1:0]        num;
   logic [NW:0]          qd;
   logic [NW:0]          rem_n;
   logic                 fix;
   logic [16:0]          mag;
   logic signed [15:0]   q14;
   logic                 load_out;
   logic signed [34:0]   fw_ext, st_ext, tn_ext;

   assign tok_pop   = (state_ff == ST_IDLE) && tok_valid;
   assign load_out  = (state_ff == ST_SUM) && (!out_valid_ff || pop);
   assign out_valid = out_valid_ff;

   assign front_left_speed  = fl_ff;
   assign back_left_speed   = bl_ff;
   assign front_right_speed = fr_ff;
   assign back_right_speed  = br_ff;

   // fraction times 2^14 over 10^digits by reciprocal: the estimate is at
   // most one low, and one compare against the remainder settles it
   assign est_sum = {prod_ff, 14'd0} + HALF_RECIP;
   assign num     = {frac_ff, 14'd0} + HALF_SCALE;
   assign qd      = (NW + 1)'(quot_ff) * SCALE_N;
   assign rem_n   = {1'b0, num} - qd;
   assign fix     = (rem_n >= SCALE_N);

   assign mag = {1'b0, cur_ff.int_part, 14'd0} + {2'd0, quot_ff};

   always_comb begin
      if (cur_ff.negative) begin
         q14 = (mag > 17'd32768) ? -16'sd32768 : 16'(-mag);
      end else begin
         q14 = (mag > 17'd32767) ? 16'sd32767 : 16'(mag);
      end
   end

   assign fw_ext = 35'(fw_prod_ff);
   assign st_ext = 35'(st_prod_ff);
   assign tn_ext = 35'(tn_prod_ff);

   always_comb begin
      state_in = state_ff;
      frac_in  = frac_ff;
      quot_in  = quot_ff;
      cur_in   = cur_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tok_valid) begin
               cur_in   = tok;
               frac_in  = tok_frac;
               quot_in  = '0;
               state_in = tok.is_line ? ST_MUL : ST_RCP;
            end
         end
         ST_RCP:  state_in = ST_EST;
         ST_EST: begin
            quot_in  = est_sum[NW +: 15];
            state_in = ST_CHK;
         end
         ST_CHK: begin
            quot_in  = quot_ff + {14'd0, fix};
            state_in = ST_FIN;
         end
         ST_FIN:  state_in = ST_IDLE;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM: begin
            if (load_out) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) out_valid_in = 1'b1;
      else if (pop) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         strafe_ff    <= '0;
         forward_ff   <= '0;
         turn_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_FIN) begin
            case (cur_ff.key_sel)
               SEL_LX:  strafe_ff  <= q14;
               SEL_LY:  forward_ff <= q14;
               SEL_YAW: turn_ff    <= q14;
               default: turn_ff    <= turn_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      frac_ff <= frac_in;
      quot_ff <= quot_in;
      cur_ff  <= cur_in;
      if (state_ff == ST_RCP) begin
         prod_ff <= (FW + 15)'(frac_ff) * (FW + 15)'(RECIP);
      end
      if (state_ff == ST_MUL) begin
         fw_prod_ff <= forward_ff * $signed({1'b0, forward_gain});
         st_prod_ff <= strafe_ff  * $signed({1'b0, forward_gain});
         tn_prod_ff <= turn_ff    * $signed({1'b0, turn_gain});
      end
      if (load_out) begin
         fl_ff <= mix_speed(fw_ext + tn_ext - st_ext);
         bl_ff <= mix_speed(fw_ext + tn_ext + st_ext);
         fr_ff <= mix_speed(fw_ext - tn_ext - st_ext);
         br_ff <= mix_speed(fw_ext - tn_ext + st_ext);
      end
   end

`ifndef NO_ASSERTIONS
   a_rem_below_two_scales: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHK |-> rem_n < (SCALE_N << 1))
      else $error("quotient estimate was more than one low");

   a_chk_ends_in_fin: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHK |=> state_ff == ST_FIN)
      else $error("conversion skipped its store step");

   a_result_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_SUM)
      else $error("result appeared without a mix");

   a_sum_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SUM && out_valid_ff && !pop |=> state_ff == ST_SUM)
      else $error("mix left while the result register was occupied");
`endif

endmodule
